### hdl/tdpc_pkg.sv
// shared types, constants and the palette table of the time-of-day crossfade unit
// used by every module in this folder; depends on nothing else

package tdpc_pkg;

  localparam int NUM_COLORS = 9;
  localparam int PAL_COUNT = 5;
  localparam int MINUTE_W = 11;
  localparam int SUN_W = 12;
  localparam int OFFSET_W = 6;
  localparam int COLOR_W = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEFAULT_RISE = 6 * 60 + 30;
  localparam int DEFAULT_SET = 19 * 60 + 30;
  localparam int BAND = 60;

  localparam logic [2:0] PAL_MIDNIGHT = 3'd0;
  localparam logic [2:0] PAL_NIGHT = 3'd1;
  localparam logic [2:0] PAL_DAWN = 3'd2;
  localparam logic [2:0] PAL_DAY = 3'd3;
  localparam logic [2:0] PAL_DUSK = 3'd4;

  localparam logic [COLOR_W-1:0] PALETTE [PAL_COUNT][NUM_COLORS] = '{
    '{16'h0021, 16'h0842, 16'h3186, 16'h18C3, 16'h3DF9, 16'h79ED, 16'h8A87, 16'h1082, 16'h4A69},
    '{16'h0823, 16'h1866, 16'h8811, 16'h4008, 16'h479E, 16'hF9F1, 16'hFBC7, 16'h1084, 16'h738E},
    '{16'h1866, 16'h494D, 16'hA25C, 16'h5AAB, 16'h7F5E, 16'hBC1F, 16'hFD4F, 16'h2124, 16'h9CDF},
    '{16'h10E9, 16'h2A30, 16'hB460, 16'h5A08, 16'h7EFF, 16'hFDE7, 16'hFCA5, 16'h18E3, 16'hAD75},
    '{16'h2822, 16'h6884, 16'hF9A0, 16'h8140, 16'hFC65, 16'hF9ED, 16'hFAC5, 16'h2082, 16'hFBAE}
  };

  // one classified request: palettes to fade between and minutes into the band
  typedef struct packed {
    logic [2:0]          from_pal;
    logic [2:0]          to_pal;
    logic [OFFSET_W-1:0] offset;
  } tdpc_entry_t;

  function automatic logic [COLOR_W-1:0] pal_color(input logic [2:0] pal,
                                                   input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    c = '0;
    if (pal < 3'(PAL_COUNT) && idx < 4'(NUM_COLORS)) begin
      c = PALETTE[pal][idx];
    end
    return c;
  endfunction

endpackage

### hdl/tdpc_front.sv
// front end: takes a minute of the day and classifies it into a fade band
// depends on tdpc_pkg; pushes one tdpc_entry_t into the queue per request

module tdpc_front import tdpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [MINUTE_W-1:0] minute_of_day,
  input  logic                minute_valid,
  output logic                minute_stall,
  input  logic [SUN_W-1:0]    sunrise_minute,
  input  logic [SUN_W-1:0]    sunset_minute,
  input  logic                queue_full,
  output logic                push,
  output tdpc_entry_t         push_entry
);

  localparam int CMP_W = 14;

  logic signed [CMP_W-1:0] now;
  logic signed [CMP_W-1:0] rise;
  logic signed [CMP_W-1:0] set_min;
  logic signed [CMP_W-1:0] rise_lo;
  logic signed [CMP_W-1:0] rise_hi;
  logic signed [CMP_W-1:0] set_lo;
  logic signed [CMP_W-1:0] set_hi;
  logic signed [CMP_W-1:0] d_rise_lo;
  logic signed [CMP_W-1:0] d_rise;
  logic signed [CMP_W-1:0] d_set_lo;
  logic signed [CMP_W-1:0] d_set;
  logic signed [CMP_W-1:0] d_240;

  assign minute_stall = queue_full;
  assign push = minute_valid && !queue_full;

  // a negative register means unknown, fall back to the fixed default
  assign now = $signed({3'b000, minute_of_day});
  assign rise = sunrise_minute[SUN_W-1] ? CMP_W'(DEFAULT_RISE)
                                        : $signed({2'b00, sunrise_minute});
  assign set_min = sunset_minute[SUN_W-1] ? CMP_W'(DEFAULT_SET)
                                          : $signed({2'b00, sunset_minute});

  assign rise_lo = rise - CMP_W'(BAND);
  assign rise_hi = rise + CMP_W'(BAND);
  assign set_lo = set_min - CMP_W'(BAND);
  assign set_hi = set_min + CMP_W'(BAND);

  assign d_rise_lo = now - rise_lo;
  assign d_rise = now - rise;
  assign d_set_lo = now - set_lo;
  assign d_set = now - set_min;
  assign d_240 = now - CMP_W'(240);

  always_comb begin
    push_entry = '{from_pal: PAL_NIGHT, to_pal: PAL_NIGHT, offset: '0};
    priority if (now >= rise_lo && now < rise) begin
      push_entry = '{from_pal: PAL_NIGHT, to_pal: PAL_DAWN, offset: d_rise_lo[OFFSET_W-1:0]};
    end else if (now >= rise && now < rise_hi) begin
      push_entry = '{from_pal: PAL_DAWN, to_pal: PAL_DAY, offset: d_rise[OFFSET_W-1:0]};
    end else if (now >= rise_hi && now < set_lo) begin
      push_entry = '{from_pal: PAL_DAY, to_pal: PAL_DAY, offset: '0};
    end else if (now >= set_lo && now < set_min) begin
      push_entry = '{from_pal: PAL_DAY, to_pal: PAL_DUSK, offset: d_set_lo[OFFSET_W-1:0]};
    end else if (now >= set_min && now < set_hi) begin
      push_entry = '{from_pal: PAL_DUSK, to_pal: PAL_NIGHT, offset: d_set[OFFSET_W-1:0]};
    end else if (now >= CMP_W'(60) && now < CMP_W'(240)) begin
      push_entry = '{from_pal: PAL_MIDNIGHT, to_pal: PAL_MIDNIGHT, offset: '0};
    end else if (now < CMP_W'(60)) begin
      push_entry = '{from_pal: PAL_NIGHT, to_pal: PAL_MIDNIGHT, offset: now[OFFSET_W-1:0]};
    end else if (now >= CMP_W'(240) && now < CMP_W'(300)) begin
      push_entry = '{from_pal: PAL_MIDNIGHT, to_pal: PAL_NIGHT, offset: d_240[OFFSET_W-1:0]};
    end else begin
      push_entry = '{from_pal: PAL_NIGHT, to_pal: PAL_NIGHT, offset: '0};
    end
  end

`ifndef SYNTHESIS
  a_offset_in_band: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.offset < OFFSET_W'(BAND)) &&
             (push_entry.from_pal != push_entry.to_pal || push_entry.offset == '0))
    else $error("classified offset outside the band");
`endif

endmodule

### hdl/tdpc_queue.sv
// short register queue between the classifier and the blend pipeline
// depends on tdpc_pkg for the entry type

module tdpc_queue import tdpc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tdpc_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        valid,
  output tdpc_entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tdpc_entry_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign head = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

### hdl/tdpc_back.sv
// back end: two-stage blend of nine rgb565 colors plus the output register
// depends on tdpc_pkg for the palette table and the entry type

module tdpc_back import tdpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  tdpc_entry_t        head,
  output logic               pop,
  output logic               palette_valid,
  input  logic               palette_stall,
  output logic [COLOR_W-1:0] colors [NUM_COLORS]
);

  logic [9:0] t17;
  logic [7:0] t;

  logic signed [15:0] pr [NUM_COLORS];
  logic signed [15:0] pg [NUM_COLORS];
  logic signed [15:0] pb [NUM_COLORS];
  logic [4:0]         ar [NUM_COLORS];
  logic [5:0]         ag [NUM_COLORS];
  logic [4:0]         ab [NUM_COLORS];

  logic               s1_valid;
  logic signed [15:0] s1_pr [NUM_COLORS];
  logic signed [15:0] s1_pg [NUM_COLORS];
  logic signed [15:0] s1_pb [NUM_COLORS];
  logic [4:0]         s1_ar [NUM_COLORS];
  logic [5:0]         s1_ag [NUM_COLORS];
  logic [4:0]         s1_ab [NUM_COLORS];

  logic [COLOR_W-1:0] colors_next [NUM_COLORS];
  logic               out_advance;
  logic               s1_advance;

  assign out_advance = !palette_valid || !palette_stall;
  assign s1_advance = !s1_valid || out_advance;
  assign pop = head_valid && s1_advance;

  // offset * 255 / 60 is offset * 17 / 4
  assign t17 = {head.offset, 4'b0000} + {4'b0000, head.offset};
  assign t = t17[9:2];

  always_comb begin
    logic [COLOR_W-1:0] ca;
    logic [COLOR_W-1:0] cb;
    logic signed [6:0]  dr;
    logic signed [6:0]  dg;
    logic signed [6:0]  db;
    logic signed [8:0]  ts;
    ts = $signed({1'b0, t});
    for (int i = 0; i < NUM_COLORS; i++) begin
      ca = pal_color(head.from_pal, 4'(i));
      cb = pal_color(head.to_pal, 4'(i));
      dr = $signed({2'b00, cb[15:11]}) - $signed({2'b00, ca[15:11]});
      dg = $signed({1'b0, cb[10:5]}) - $signed({1'b0, ca[10:5]});
      db = $signed({2'b00, cb[4:0]}) - $signed({2'b00, ca[4:0]});
      pr[i] = 16'(dr * ts);
      pg[i] = 16'(dg * ts);
      pb[i] = 16'(db * ts);
      ar[i] = ca[15:11];
      ag[i] = ca[10:5];
      ab[i] = ca[4:0];
    end
  end

  // a + floor(d * t / 256), arithmetic shift rounds toward minus infinity
  always_comb begin
    logic signed [8:0] sr;
    logic signed [8:0] sg;
    logic signed [8:0] sb;
    for (int i = 0; i < NUM_COLORS; i++) begin
      sr = $signed({4'b0000, s1_ar[i]}) + 9'(s1_pr[i] >>> 8);
      sg = $signed({3'b000, s1_ag[i]}) + 9'(s1_pg[i] >>> 8);
      sb = $signed({4'b0000, s1_ab[i]}) + 9'(s1_pb[i] >>> 8);
      colors_next[i] = {sr[4:0], sg[5:0], sb[4:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      palette_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        s1_valid <= head_valid;
      end
      if (out_advance) begin
        palette_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_pr <= pr;
      s1_pg <= pg;
      s1_pb <= pb;
      s1_ar <= ar;
      s1_ag <= ag;
      s1_ab <= ab;
    end
    if (out_advance && s1_valid) begin
      colors <= colors_next;
    end
  end

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_pg[0]) && $stable(s1_ar[0]))
    else $error("blend stage overwritten while output stalled");
`endif

endmodule

### hdl/time_of_day_palette_crossfade_unit.sv
// throughput: one request per cycle while minute_stall is low;
// the four-entry queue and output register absorb stalls
// the path is classifier, queue register, multiply stage, add stage into the output register
// reset: synchronous, clears queue and pipeline valids, sunrise and sunset read back as -1
// depends on tdpc_pkg, tdpc_front, tdpc_queue and tdpc_back

module time_of_day_palette_crossfade_unit import tdpc_pkg::*; #(
  parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic [MINUTE_W-1:0] minute_of_day,
  input  logic                minute_valid,
  output logic                minute_stall,
  output logic [COLOR_W-1:0]  sky_top_color,
  output logic [COLOR_W-1:0]  sky_bottom_color,
  output logic [COLOR_W-1:0]  grid_color,
  output logic [COLOR_W-1:0]  grid_dim_color,
  output logic [COLOR_W-1:0]  ink_color,
  output logic [COLOR_W-1:0]  sun_top_color,
  output logic [COLOR_W-1:0]  sun_bottom_color,
  output logic [COLOR_W-1:0]  panel_color,
  output logic [COLOR_W-1:0]  label_color,
  output logic                palette_valid,
  input  logic                palette_stall
);

  localparam logic REG_SUNRISE = 1'b0;
  localparam logic REG_SUNSET = 1'b1;

  logic [SUN_W-1:0]   sunrise_minute;
  logic [SUN_W-1:0]   sunset_minute;
  logic               cfg_write;
  logic               push;
  tdpc_entry_t        push_entry;
  logic               queue_full;
  logic               pop;
  logic               head_valid;
  tdpc_entry_t        head;
  logic [COLOR_W-1:0] colors [NUM_COLORS];

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sunrise_minute <= '1;
      sunset_minute <= '1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SUNRISE: sunrise_minute <= pwdata[SUN_W-1:0];
        REG_SUNSET:  sunset_minute <= pwdata[SUN_W-1:0];
        default:     sunrise_minute <= sunrise_minute;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SUNRISE: prdata = {{(32 - SUN_W){sunrise_minute[SUN_W-1]}}, sunrise_minute};
      REG_SUNSET:  prdata = {{(32 - SUN_W){sunset_minute[SUN_W-1]}}, sunset_minute};
      default:     prdata = '0;
    endcase
  end

  tdpc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .minute_of_day  (minute_of_day),
    .minute_valid   (minute_valid),
    .minute_stall   (minute_stall),
    .sunrise_minute (sunrise_minute),
    .sunset_minute  (sunset_minute),
    .queue_full     (queue_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  tdpc_queue #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .valid      (head_valid),
    .head       (head)
  );

  tdpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .palette_valid (palette_valid),
    .palette_stall (palette_stall),
    .colors        (colors)
  );

  assign sky_top_color = colors[0];
  assign sky_bottom_color = colors[1];
  assign grid_color = colors[2];
  assign grid_dim_color = colors[3];
  assign ink_color = colors[4];
  assign sun_top_color = colors[5];
  assign sun_bottom_color = colors[6];
  assign panel_color = colors[7];
  assign label_color = colors[8];

endmodule
